FILE: src/srrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrt_pkg: shared types and codes for the sorted region range table
// Operation and status codes, the per-cell move command and the compare
// flags that each cell returns to the control logic.
// ----------------------------------------------------------------------------
package srrt_pkg;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int USED_W   = 5;

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERLAP  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  // What a cell loads on the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_LOAD    = 2'd1,
    CELL_FROM_LO = 2'd2,
    CELL_FROM_HI = 2'd3
  } cell_op_t;

  // Compare results of one cell against the current command.
  typedef struct packed {
    logic overlap;
    logic start_lt;
    logic tag_eq;
    logic contains;
  } cell_flag_t;

endpackage

FILE: src/srrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrt_cell: one entry of the range table
// Holds one range and its tag, compares it against the broadcast command
// every cycle and moves data to or from its neighbors on command.
// ----------------------------------------------------------------------------
module srrt_cell #(
  parameter int ADDR_BITS = 48,
  parameter int TAG_BITS  = 8
) (
  input  logic                 clk,
  input  srrt_pkg::cell_op_t   op,
  input  logic [ADDR_BITS-1:0] cmd_start,
  input  logic [ADDR_BITS-1:0] cmd_end,
  input  logic [TAG_BITS-1:0]  cmd_tag,
  input  logic [ADDR_BITS-1:0] cmd_probe,
  input  logic [ADDR_BITS-1:0] lo_start,
  input  logic [ADDR_BITS-1:0] lo_end,
  input  logic [TAG_BITS-1:0]  lo_tag,
  input  logic [ADDR_BITS-1:0] hi_start,
  input  logic [ADDR_BITS-1:0] hi_end,
  input  logic [TAG_BITS-1:0]  hi_tag,
  output logic [ADDR_BITS-1:0] ent_start,
  output logic [ADDR_BITS-1:0] ent_end,
  output logic [TAG_BITS-1:0]  ent_tag,
  output srrt_pkg::cell_flag_t flags
);
  import srrt_pkg::*;

  logic [ADDR_BITS-1:0] start_r, start_nxt;
  logic [ADDR_BITS-1:0] end_r, end_nxt;
  logic [TAG_BITS-1:0]  tag_r, tag_nxt;
  cell_flag_t           flags_r, flags_nxt;

  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    tag_nxt   = tag_r;
    case (op)
      CELL_HOLD: begin
      end
      CELL_LOAD: begin
        start_nxt = cmd_start;
        end_nxt   = cmd_end;
        tag_nxt   = cmd_tag;
      end
      CELL_FROM_LO: begin
        start_nxt = lo_start;
        end_nxt   = lo_end;
        tag_nxt   = lo_tag;
      end
      CELL_FROM_HI: begin
        start_nxt = hi_start;
        end_nxt   = hi_end;
        tag_nxt   = hi_tag;
      end
      default: begin
      end
    endcase
  end

  // Compare held range against the command.
  always_comb begin
    flags_nxt.overlap  = (cmd_start < end_r) && (start_r < cmd_end);
    flags_nxt.start_lt = start_r < cmd_start;
    flags_nxt.tag_eq   = tag_r == cmd_tag;
    flags_nxt.contains = (cmd_probe >= start_r) && (cmd_probe < end_r);
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    end_r   <= end_nxt;
    tag_r   <= tag_nxt;
    flags_r <= flags_nxt;
  end

  assign ent_start = start_r;
  assign ent_end   = end_r;
  assign ent_tag   = tag_r;
  assign flags     = flags_r;

endmodule

FILE: src/sorted_region_range_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_region_range_table: sorted table of tagged address ranges
// Add, remove-by-tag and address lookup over a chain of range cells.
// ----------------------------------------------------------------------------
// The table holds up to MAX_REGIONS non-overlapping half-open ranges
// [start,end), kept sorted by start in a row of cells, each with a tag. Every
// transaction on the input side yields exactly one transaction on the result
// side: an add is rejected as empty, overlapping or full (in that order) or
// slides into sorted position; a remove drops the lowest-addressed entry with
// the given tag or reports it missing; a lookup returns the tag of the range
// holding the probe address. An item passes S_CMP, where every cell compares
// its range with the command and registers the outcome, then S_APPLY, where
// the control logic reduces those flags, commits the shift along the chain
// and loads the result register. A new item is taken while idle or in S_APPLY
// as the last one commits; that commit waits while a finished result is
// still held by out_stall. Entries at or above the count are never trusted,
// so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module sorted_region_range_table #(
  parameter int MAX_REGIONS = 16,
  parameter int ADDR_BITS   = 48,
  parameter int TAG_BITS    = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [srrt_pkg::KIND_W-1:0]     in_kind,
  input  logic [ADDR_BITS-1:0]            in_range_start,
  input  logic [ADDR_BITS-1:0]            in_range_end,
  input  logic [TAG_BITS-1:0]             in_region_tag,
  input  logic [ADDR_BITS-1:0]            in_probe_address,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [srrt_pkg::STATUS_W-1:0]   out_status,
  output logic                            out_hit,
  output logic [TAG_BITS-1:0]             out_hit_tag,
  output logic [srrt_pkg::USED_W-1:0]     out_entries_used
);
  import srrt_pkg::*;

  localparam int N     = MAX_REGIONS;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Command registers, loaded on each accepted transaction.
  logic [KIND_W-1:0]    cmd_kind_r, cmd_kind_nxt;
  logic [ADDR_BITS-1:0] cmd_start_r, cmd_start_nxt;
  logic [ADDR_BITS-1:0] cmd_end_r, cmd_end_nxt;
  logic [TAG_BITS-1:0]  cmd_tag_r, cmd_tag_nxt;
  logic [ADDR_BITS-1:0] cmd_probe_r, cmd_probe_nxt;

  logic [CNT_W-1:0]     count_r, count_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic [TAG_BITS-1:0]  out_hit_tag_r, out_hit_tag_nxt;
  logic [CNT_W-1:0]     out_count_r, out_count_nxt;

  // Chain wiring.
  logic [ADDR_BITS-1:0] ent_start [N];
  logic [ADDR_BITS-1:0] ent_end   [N];
  logic [TAG_BITS-1:0]  ent_tag   [N];
  cell_flag_t           cell_flag [N];
  cell_op_t             cell_op   [N];

  logic [N-1:0] occ;
  logic [N-1:0] ov_v, lt_v, tm_v, ct_v;
  logic [N-1:0] lt_prev;
  logic [N-1:0] tm_neg, tm_ge;
  logic [N-1:0] ct_neg, ct_first;
  logic [TAG_BITS-1:0] hit_tag_sel;

  logic accept, apply_go, full, range_empty;
  logic do_insert, do_delete;
  logic [STATUS_W-1:0] status_sel;

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      logic [ADDR_BITS-1:0] lo_start, lo_end, hi_start, hi_end;
      logic [TAG_BITS-1:0]  lo_tag, hi_tag;

      // Cell 0 never takes from below, the last cell never from above.
      if (gi == 0) begin : g_lo_edge
        assign lo_start = cmd_start_r;
        assign lo_end   = cmd_end_r;
        assign lo_tag   = cmd_tag_r;
      end else begin : g_lo
        assign lo_start = ent_start[gi-1];
        assign lo_end   = ent_end[gi-1];
        assign lo_tag   = ent_tag[gi-1];
      end
      if (gi == N - 1) begin : g_hi_edge
        assign hi_start = ent_start[gi];
        assign hi_end   = ent_end[gi];
        assign hi_tag   = ent_tag[gi];
      end else begin : g_hi
        assign hi_start = ent_start[gi+1];
        assign hi_end   = ent_end[gi+1];
        assign hi_tag   = ent_tag[gi+1];
      end

      srrt_cell #(
        .ADDR_BITS (ADDR_BITS),
        .TAG_BITS  (TAG_BITS)
      ) u_cell (
        .clk       (clk),
        .op        (cell_op[gi]),
        .cmd_start (cmd_start_r),
        .cmd_end   (cmd_end_r),
        .cmd_tag   (cmd_tag_r),
        .cmd_probe (cmd_probe_r),
        .lo_start  (lo_start),
        .lo_end    (lo_end),
        .lo_tag    (lo_tag),
        .hi_start  (hi_start),
        .hi_end    (hi_end),
        .hi_tag    (hi_tag),
        .ent_start (ent_start[gi]),
        .ent_end   (ent_end[gi]),
        .ent_tag   (ent_tag[gi]),
        .flags     (cell_flag[gi])
      );

      // Only entries below the count hold live ranges.
      assign occ[gi]  = CNT_W'(gi) < count_r;
      assign ov_v[gi] = cell_flag[gi].overlap  & occ[gi];
      assign lt_v[gi] = cell_flag[gi].start_lt & occ[gi];
      assign tm_v[gi] = cell_flag[gi].tag_eq   & occ[gi];
      assign ct_v[gi] = cell_flag[gi].contains & occ[gi];
    end
  endgenerate

  // Entries below the new start form a prefix; the insert slot sits at its
  // upper edge. lt_prev[i] is lt_v[i-1], with a one below cell 0.
  assign lt_prev = N'({lt_v, 1'b1});

  // From the first tag match upward everything slides down one cell.
  assign tm_neg = ~tm_v + N'(1);
  assign tm_ge  = tm_v | tm_neg;

  // Isolate the first containing entry.
  assign ct_neg   = ~ct_v + N'(1);
  assign ct_first = ct_v & ct_neg;

  always_comb begin
    hit_tag_sel = '0;
    for (int i = 0; i < N; i++) begin
      hit_tag_sel = hit_tag_sel | ({TAG_BITS{ct_first[i]}} & ent_tag[i]);
    end
  end

  assign full        = count_r == CNT_W'(MAX_REGIONS);
  assign range_empty = !(cmd_start_r < cmd_end_r);

  // Result of the command under evaluation.
  always_comb begin
    status_sel = ST_OK;
    do_insert  = 1'b0;
    do_delete  = 1'b0;
    case (cmd_kind_r)
      KIND_ADD: begin
        if (range_empty) begin
          status_sel = ST_EMPTY;
        end else if (|ov_v) begin
          status_sel = ST_OVERLAP;
        end else if (full) begin
          status_sel = ST_FULL;
        end else begin
          do_insert = 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (|tm_v) begin
          do_delete = 1'b1;
        end else begin
          status_sel = ST_NOTFOUND;
        end
      end
      default: begin
        status_sel = ST_OK;
      end
    endcase
  end

  // Commit only when the result register can take the outcome.
  assign apply_go = (state_r == S_APPLY) && (!out_valid_r || !out_stall);
  assign in_stall = !((state_r == S_IDLE) || apply_go);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      cell_op[i] = CELL_HOLD;
      if (apply_go && do_insert) begin
        if (lt_v[i]) begin
          cell_op[i] = CELL_HOLD;
        end else if (lt_prev[i]) begin
          cell_op[i] = CELL_LOAD;
        end else begin
          cell_op[i] = CELL_FROM_LO;
        end
      end else if (apply_go && do_delete && tm_ge[i]) begin
        cell_op[i] = CELL_FROM_HI;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (apply_go) begin
          state_nxt = accept ? S_CMP : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Capture the command on accept.
  always_comb begin
    cmd_kind_nxt  = cmd_kind_r;
    cmd_start_nxt = cmd_start_r;
    cmd_end_nxt   = cmd_end_r;
    cmd_tag_nxt   = cmd_tag_r;
    cmd_probe_nxt = cmd_probe_r;
    if (accept) begin
      cmd_kind_nxt  = in_kind;
      cmd_start_nxt = in_range_start;
      cmd_end_nxt   = in_range_end;
      cmd_tag_nxt   = in_region_tag;
      cmd_probe_nxt = in_probe_address;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (apply_go && do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (apply_go && do_delete) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Result register: load on commit, drop once taken.
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_hit_nxt     = out_hit_r;
    out_hit_tag_nxt = out_hit_tag_r;
    out_count_nxt   = out_count_r;
    if (apply_go) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = status_sel;
      out_hit_nxt     = (cmd_kind_r == KIND_LOOKUP) && (|ct_v);
      out_hit_tag_nxt = (cmd_kind_r == KIND_LOOKUP) ? hit_tag_sel : '0;
      out_count_nxt   = count_nxt;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_kind_r    <= cmd_kind_nxt;
    cmd_start_r   <= cmd_start_nxt;
    cmd_end_r     <= cmd_end_nxt;
    cmd_tag_r     <= cmd_tag_nxt;
    cmd_probe_r   <= cmd_probe_nxt;
    out_status_r  <= out_status_nxt;
    out_hit_r     <= out_hit_nxt;
    out_hit_tag_r <= out_hit_tag_nxt;
    out_count_r   <= out_count_nxt;
  end

  logic [CNT_W+USED_W-1:0] count_ext;
  assign count_ext = {{USED_W{1'b0}}, out_count_r};

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_hit          = out_hit_r;
  assign out_hit_tag      = out_hit_tag_r;
  assign out_entries_used = count_ext[USED_W-1:0];

  // Table never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_REGIONS))
    else $error("entry count beyond capacity");

  // An accepted transaction always goes to the compare cycle.
  a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_CMP)
    else $error("accepted transaction skipped compare");

  // A committed insert grows the table by exactly one.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (apply_go && do_insert) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not advance count");

  // Stored ranges never overlap, so a probe lands in at most one entry.
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY && cmd_kind_r == KIND_LOOKUP) |-> $onehot0(ct_v))
    else $error("probe matched more than one range");

  // A result is presented only once it has been computed.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_APPLY)
    else $error("result raised outside commit");

endmodule

FILE: dv/sorted_region_range_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_region_range_table_test: self-checking bench for the range table
// Drives add, remove-by-tag and lookup transactions into the table, predicts
// every result with a behavioral copy of the sorted table and compares each
// result field by field, under random idling on both channels.
// ----------------------------------------------------------------------------
module sorted_region_range_table_test;
  import srrt_pkg::*;

  localparam int DEPTH        = 16;
  localparam int ADDR_W       = 48;
  localparam int TAG_W        = 8;
  localparam int IDLE_PCT     = 37;
  localparam int RESET_CYCLES = 2;
  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1700;

  // The package names only the three live operations; code 3 is a no-op.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [TAG_W-1:0]  tag_t;

  localparam addr_t ADDR_ONES  = {ADDR_W{1'b1}};
  localparam addr_t WINDOW_TOP = ADDR_ONES - addr_t'(1200);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    addr_t             lo;
    addr_t             hi;
    tag_t              tag;
    addr_t             probe;
  } table_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                hit;
    tag_t                hit_tag;
    logic [USED_W-1:0]   used;
  } table_reply_t;

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   in_kind          = '0;
  addr_t               in_range_start   = '0;
  addr_t               in_range_end     = '0;
  tag_t                in_region_tag    = '0;
  addr_t               in_probe_address = '0;
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic                out_hit;
  tag_t                out_hit_tag;
  logic [USED_W-1:0]   out_entries_used;

  // Shadow copy of the table: sorted by start, only slots below rg_count live.
  addr_t rg_start [DEPTH];
  addr_t rg_end   [DEPTH];
  tag_t  rg_tag   [DEPTH];
  int    rg_count = 0;

  table_reply_t reply_q[$];

  int    send_idle_pct  = IDLE_PCT;
  int    recv_stall_pct = IDLE_PCT;
  int    error_count    = 0;
  int    quiet_cycles   = 0;
  addr_t window         = '0;

  sorted_region_range_table #(
    .MAX_REGIONS(DEPTH),
    .ADDR_BITS  (ADDR_W),
    .TAG_BITS   (TAG_W)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_range_start  (in_range_start),
    .in_range_end    (in_range_end),
    .in_region_tag   (in_region_tag),
    .in_probe_address(in_probe_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_hit         (out_hit),
    .out_hit_tag     (out_hit_tag),
    .out_entries_used(out_entries_used)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Table predictor: apply one accepted transaction to the shadow table and
  // return the result the block must produce for it.
  // --------------------------------------------------------------------------
  function automatic table_reply_t table_apply(table_op_t op);
    table_reply_t r;
    logic         clash;
    int           pos;
    int           idx;
    r     = '0;
    clash = 1'b0;
    pos   = 0;
    idx   = rg_count;
    r.status = ST_OK;
    case (op.kind)
      KIND_ADD: begin
        // Check order matters: empty beats overlap beats full.
        if (op.lo >= op.hi) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < rg_count; i++)
            if (op.lo < rg_end[i] && rg_start[i] < op.hi) clash = 1'b1;
          if (clash) begin
            r.status = ST_OVERLAP;
          end else if (rg_count >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            // Slide in after every entry with a smaller start.
            while (pos < rg_count && rg_start[pos] < op.lo) pos++;
            for (int i = rg_count; i > pos; i--) begin
              rg_start[i] = rg_start[i-1];
              rg_end[i]   = rg_end[i-1];
              rg_tag[i]   = rg_tag[i-1];
            end
            rg_start[pos] = op.lo;
            rg_end[pos]   = op.hi;
            rg_tag[pos]   = op.tag;
            rg_count++;
          end
        end
      end
      KIND_REMOVE: begin
        // Drop only the lowest-addressed entry carrying the tag.
        for (int i = rg_count - 1; i >= 0; i--)
          if (rg_tag[i] == op.tag) idx = i;
        if (idx == rg_count) begin
          r.status = ST_NOTFOUND;
        end else begin
          for (int i = idx; i + 1 < rg_count; i++) begin
            rg_start[i] = rg_start[i+1];
            rg_end[i]   = rg_end[i+1];
            rg_tag[i]   = rg_tag[i+1];
          end
          rg_count--;
        end
      end
      KIND_LOOKUP: begin
        for (int i = rg_count - 1; i >= 0; i--)
          if (op.probe >= rg_start[i] && op.probe < rg_end[i]) begin
            r.hit     = 1'b1;
            r.hit_tag = rg_tag[i];
          end
      end
      default: begin
      end
    endcase
    r.used = rg_count[USED_W-1:0];
    return r;
  endfunction

  function automatic table_op_t make_op(logic [KIND_W-1:0] kind, addr_t lo, addr_t hi,
                                        tag_t tag, addr_t probe);
    table_op_t op;
    op.kind  = kind;
    op.lo    = lo;
    op.hi    = hi;
    op.tag   = tag;
    op.probe = probe;
    return op;
  endfunction

  function automatic addr_t rand_addr();
    return addr_t'({$urandom, $urandom});
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender: idle at random, then hold the transaction until the block takes
  // it. Leave valid high afterwards so back-to-back items need no gap; every
  // caller that waits on anything else lowers it first.
  // --------------------------------------------------------------------------
  task automatic send_op(input table_op_t op);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= op.kind;
    in_range_start   <= op.lo;
    in_range_end     <= op.hi;
    in_region_tag    <= op.tag;
    in_probe_address <= op.probe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Accepted at this edge: advance the shadow table and queue the result.
    reply_q.insert(reply_q.size(), table_apply(op));
  endtask

  // Stop sending until every queued result has come back.
  task automatic hold_sender();
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall at random. Drive at the rising edge only.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Result checker and watchdog. Sample at the falling edge: inputs and
  // outputs only move at the rising edge, so what is seen here is exactly
  // what the next rising edge will accept. A result taken at an edge is
  // checked at the falling edge before it; an item taken at that edge is queued at
  // the edge itself, so the two never race.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    table_reply_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          error_count++;
          $error("result transaction with no pending expectation");
        end else begin
          want = reply_q.pop_front();
          compare_field("status", want.status, out_status);
          compare_field("hit", want.hit, out_hit);
          compare_field("hit_tag", want.hit_tag, out_hit_tag);
          compare_field("entries_used", want.used, out_entries_used);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $error("watchdog: no transaction for %0d cycles", STALL_LIMIT);
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // An empty table misses every lookup and knows no tag.
  task automatic test_empty_table();
    send_op(make_op(KIND_LOOKUP, '0, '0, '0, '0));
    send_op(make_op(KIND_REMOVE, '0, '0, '0, '0));
  endtask

  // Empty ranges (equal and reversed ends), overlap, touching ranges,
  // duplicate tags and ranges at both ends of the address space.
  task automatic test_add_checks();
    send_op(make_op(KIND_ADD, addr_t'(5), addr_t'(5), 8'h11, '0));
    send_op(make_op(KIND_ADD, addr_t'(10), addr_t'(5), 8'h12, '0));
    send_op(make_op(KIND_ADD, addr_t'(100), addr_t'(200), 8'hA5, '0));
    send_op(make_op(KIND_ADD, addr_t'(150), addr_t'(250), 8'h13, '0));
    send_op(make_op(KIND_ADD, addr_t'(200), addr_t'(300), 8'h5A, '0));
    send_op(make_op(KIND_ADD, addr_t'(50), addr_t'(100), 8'h5A, '0));
    send_op(make_op(KIND_ADD, ADDR_ONES - 1'b1, ADDR_ONES, 8'hFF, '0));
    send_op(make_op(KIND_ADD, addr_t'(0), addr_t'(1), 8'h00, '0));
  endtask

  // Lookups on range edges: the end address belongs to the next range.
  task automatic test_lookups();
    send_op(make_op(KIND_LOOKUP, '0, '0, '0, addr_t'(199)));
    send_op(make_op(KIND_LOOKUP, '0, '0, '0, addr_t'(200)));
    send_op(make_op(KIND_LOOKUP, '0, '0, '0, addr_t'(49)));
    send_op(make_op(KIND_LOOKUP, ADDR_ONES, ADDR_ONES, 8'hFF, ADDR_ONES));
    send_op(make_op(KIND_LOOKUP, '0, '0, '0, ADDR_ONES - 1'b1));
    hold_sender();
  endtask

  // Two entries share a tag: only the lower one goes.
  task automatic test_remove_duplicate();
    send_op(make_op(KIND_REMOVE, '0, '0, 8'h5A, '0));
    send_op(make_op(KIND_LOOKUP, '0, '0, '0, addr_t'(60)));
    send_op(make_op(KIND_LOOKUP, '0, '0, '0, addr_t'(250)));
  endtask

  // Fill every slot, then check that full ranks after empty and overlap.
  task automatic test_full_table();
    for (int k = 0; rg_count < DEPTH; k++)
      send_op(make_op(KIND_ADD, addr_t'(1000 + 16 * k), addr_t'(1008 + 16 * k),
                      tag_t'(k), '0));
    send_op(make_op(KIND_ADD, addr_t'(5000), addr_t'(5010), 8'h77, '0));
    send_op(make_op(KIND_ADD, addr_t'(1000), addr_t'(1004), 8'h78, '0));
    send_op(make_op(KIND_ADD, addr_t'(7), addr_t'(7), 8'h79, '0));
  endtask

  // The unused operation code leaves the table alone.
  task automatic test_spare_kind();
    send_op(make_op(KIND_SPARE, ADDR_ONES, ADDR_ONES, 8'hFF, ADDR_ONES));
  endtask

  // --------------------------------------------------------------------------
  // Random traffic. Most adds land in a narrow address window so that they
  // collide, fill the table and get removed again; most lookups and removes
  // aim at live entries. Fields an operation ignores carry random bits.
  // --------------------------------------------------------------------------
  task automatic test_random_traffic(input int count);
    table_op_t op;
    int        pick;
    int        slot;
    int        add_share;
    addr_t     span;
    for (int n = 0; n < count; n++) begin
      // Move the window now and then: bottom, top or anywhere in between.
      if (n % 100 == 0) begin
        pick = $urandom_range(0, 2);
        if (pick == 0) window = '0;
        else if (pick == 1) window = WINDOW_TOP;
        else begin
          window = rand_addr();
          if (window > WINDOW_TOP) window = WINDOW_TOP;
        end
      end
      // Run a stretch at full rate on both sides.
      if (n == 600) begin
        send_idle_pct  = 0;
        recv_stall_pct <= 0;
      end
      if (n == 900) begin
        send_idle_pct  = IDLE_PCT;
        recv_stall_pct <= IDLE_PCT;
      end
      if (n % 400 == 399) hold_sender();

      op = make_op(KIND_LOOKUP, rand_addr(), rand_addr(), tag_t'($urandom), rand_addr());
      // Lean toward removes when the table is nearly full, adds when nearly empty.
      add_share = (rg_count >= DEPTH - 2) ? 30 : (rg_count <= 3) ? 65 : 45;
      pick = $urandom_range(0, 99);
      if (pick < add_share) begin
        op.kind = KIND_ADD;
        if ($urandom_range(0, 1) == 1) op.tag = tag_t'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        // Below 4: keep the fully random ends (huge or reversed ranges).
        if (pick >= 4) begin
          op.lo = window + addr_t'($urandom_range(0, 1023));
          if (pick < 10) op.hi = op.lo - addr_t'($urandom_range(0, 1));
          else op.hi = op.lo + addr_t'($urandom_range(1, 64));
        end
      end else if (pick < add_share + 25) begin
        op.kind = KIND_REMOVE;
        if (rg_count > 0 && $urandom_range(0, 99) < 80)
          op.tag = rg_tag[$urandom_range(0, rg_count - 1)];
      end else if (pick < 97) begin
        if (rg_count > 0 && $urandom_range(0, 99) < 75) begin
          slot = $urandom_range(0, rg_count - 1);
          span = rg_end[slot] - rg_start[slot];
          case ($urandom_range(0, 4))
            0:       op.probe = rg_start[slot];
            1:       op.probe = rg_end[slot] - 1'b1;
            2:       op.probe = rg_end[slot];
            3:       op.probe = rg_start[slot] - 1'b1;
            default: op.probe = rg_start[slot] + rand_addr() % span;
          endcase
        end else if ($urandom_range(0, 1) == 1) begin
          op.probe = window + addr_t'($urandom_range(0, 1100));
        end
      end else begin
        op.kind = KIND_SPARE;
      end
      send_op(op);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_add_checks();
    test_lookups();
    test_remove_duplicate();
    test_full_table();
    test_spare_kind();
    test_random_traffic(RANDOM_ITEMS);

    // Drain: wait for every result, then keep watching for stray ones.
    hold_sender();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/srrt_pkg.sv
src/srrt_cell.sv
src/sorted_region_range_table.sv
dv/sorted_region_range_table_test.sv
